// ===== design/mpsd_pkg.sv =====
//------------------------------------------------------------------------------
// mpsd_pkg
// Shared types and constants of the motion pickup and shake detector.
//------------------------------------------------------------------------------
`default_nettype none

package mpsd_pkg;

    // Width of the squared acceleration norm and of every timestamp.
    localparam int NORM_W = 32;
    localparam int TIME_W = 32;
    localparam int ROT_W  = 17;
    localparam int CNT_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_INDEX_W = 3;

    // Consecutive motion samples that make a pickup.
    localparam logic [CNT_W-1:0] PICKUP_RUN_NEEDED = 4'd3;
    localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

    // Reset values of the configuration registers.
    localparam logic [16:0] RST_PICKUP_ROT_MIN   = 17'd5000;
    localparam logic [31:0] RST_PICKUP_DELTA_MIN = 32'd6000000;
    localparam logic [15:0] RST_PICKUP_COOLDOWN  = 16'd5000;
    localparam logic [16:0] RST_SHAKE_ROT_MIN    = 17'd30000;
    localparam logic [31:0] RST_SHAKE_DELTA_MIN  = 32'd16000000;
    localparam logic [3:0]  RST_SHAKE_PEAKS      = 4'd3;
    localparam logic [15:0] RST_SHAKE_WINDOW     = 16'd900;
    localparam logic [15:0] RST_SHAKE_PEAK_GAP   = 16'd80;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PICKUP_ROT_MIN   = 3'd0,
        REG_PICKUP_DELTA_MIN = 3'd1,
        REG_PICKUP_COOLDOWN  = 3'd2,
        REG_SHAKE_ROT_MIN    = 3'd3,
        REG_SHAKE_DELTA_MIN  = 3'd4,
        REG_SHAKE_PEAKS      = 3'd5,
        REG_SHAKE_WINDOW     = 3'd6,
        REG_SHAKE_PEAK_GAP   = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [ROT_W-1:0]  pickup_rot_min;
        logic [NORM_W-1:0] pickup_delta_min;
        logic [15:0]       pickup_cooldown;
        logic [ROT_W-1:0]  shake_rot_min;
        logic [NORM_W-1:0] shake_delta_min;
        logic [CNT_W-1:0]  shake_peaks_needed;
        logic [15:0]       shake_window;
        logic [15:0]       shake_peak_gap;
    } cfg_t;

    // Result of one detector update.
    typedef struct packed {
        logic              pickup_event;
        logic              shake_event;
        logic [NORM_W-1:0] norm_change;
    } det_result_t;

    // Magnitude of a 16-bit two's complement sample, 0 to 32768.
    function automatic logic [15:0] mag16(input logic [15:0] raw);
        logic [15:0] neg;
        begin
            neg = (~raw) + 16'd1;
            mag16 = raw[15] ? neg : raw;
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/mpsd_core.sv =====
//------------------------------------------------------------------------------
// mpsd_core
// Per-sample detector state: norm change, shake peak window and pickup run.
//------------------------------------------------------------------------------
`default_nettype none

module mpsd_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire mpsd_pkg::cfg_t              cfg,
    input  wire logic [mpsd_pkg::NORM_W-1:0] norm,
    input  wire logic [mpsd_pkg::ROT_W-1:0]  rot,
    input  wire logic [mpsd_pkg::TIME_W-1:0] now,
    output mpsd_pkg::det_result_t            result
);
    import mpsd_pkg::*;

    logic [NORM_W-1:0] prev_norm_reg;
    logic              first_reg;
    logic [CNT_W-1:0]  pickup_run_reg, pickup_run_next;
    logic [TIME_W-1:0] last_pickup_reg, last_pickup_next;
    logic [TIME_W-1:0] win_start_reg, win_start_next;
    logic [TIME_W-1:0] last_peak_reg, last_peak_next;
    logic [CNT_W-1:0]  peak_count_reg, peak_count_next;

    logic [NORM_W-1:0] change;
    logic [TIME_W-1:0] el_win, el_peak, el_pick;
    logic              hard_hit, motion, win_over;
    logic              shake, pick;
    logic [CNT_W-1:0]  run_inc;

    assign el_win  = now - win_start_reg;
    assign el_peak = now - last_peak_reg;
    assign el_pick = now - last_pickup_reg;
    assign win_over = el_win > {16'd0, cfg.shake_window};

    always_comb
    begin
        if (first_reg)
            change = '0;
        else if (norm >= prev_norm_reg)
            change = norm - prev_norm_reg;
        else
            change = prev_norm_reg - norm;
    end

    assign hard_hit = (rot > cfg.shake_rot_min) && (change > cfg.shake_delta_min);
    assign motion   = !hard_hit && ((rot > cfg.pickup_rot_min) ||
                                    (change > cfg.pickup_delta_min));

    always_comb
    begin
        win_start_next  = win_start_reg;
        last_peak_next  = last_peak_reg;
        peak_count_next = peak_count_reg;
        shake           = 1'b0;
        if (!hard_hit)
        begin
            // A window opened at time zero never expires here.
            if ((win_start_reg != '0) && win_over)
            begin
                peak_count_next = '0;
                win_start_next  = '0;
                last_peak_next  = '0;
            end
        end
        else
        begin
            if ((peak_count_reg == '0) || win_over)
            begin
                win_start_next  = now;
                last_peak_next  = now;
                peak_count_next = 4'd1;
            end
            else if (el_peak >= {16'd0, cfg.shake_peak_gap})
            begin
                last_peak_next = now;
                if (peak_count_reg < CNT_MAX)
                    peak_count_next = peak_count_reg + 4'd1;
            end
            if (peak_count_next >= cfg.shake_peaks_needed)
            begin
                shake           = 1'b1;
                peak_count_next = '0;
                win_start_next  = '0;
                last_peak_next  = '0;
            end
        end
    end

    always_comb
    begin
        if (!motion)
            run_inc = '0;
        else if (pickup_run_reg < CNT_MAX)
            run_inc = pickup_run_reg + 4'd1;
        else
            run_inc = pickup_run_reg;
        pick             = 1'b0;
        pickup_run_next  = run_inc;
        last_pickup_next = last_pickup_reg;
        if ((run_inc >= PICKUP_RUN_NEEDED) && (el_pick >= {16'd0, cfg.pickup_cooldown}))
        begin
            pick             = 1'b1;
            pickup_run_next  = '0;
            last_pickup_next = now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_norm_reg   <= '0;
            first_reg       <= 1'b1;
            pickup_run_reg  <= '0;
            last_pickup_reg <= '0;
            win_start_reg   <= '0;
            last_peak_reg   <= '0;
            peak_count_reg  <= '0;
        end
        else if (step)
        begin
            prev_norm_reg   <= norm;
            first_reg       <= 1'b0;
            pickup_run_reg  <= pickup_run_next;
            last_pickup_reg <= last_pickup_next;
            win_start_reg   <= win_start_next;
            last_peak_reg   <= last_peak_next;
            peak_count_reg  <= peak_count_next;
        end
    end

    assign result.pickup_event = pick;
    assign result.shake_event  = shake;
    assign result.norm_change  = change;

endmodule

`default_nettype wire

// ===== design/motion_pickup_shake_detector.sv =====
// Each word is registered in the squaring stage, then in the result register.
// Throughput: one word per cycle; the squaring stage and the detector stage
// both advance every cycle unless the result register is held by out_stall.
// Reset: rst_n clears the pipeline valid flags and the detector state and
// loads the default thresholds into the configuration registers.
//------------------------------------------------------------------------------
// motion_pickup_shake_detector
// Accelerometer norm change, shake peak counting and pickup detection.
//------------------------------------------------------------------------------
`default_nettype none

module motion_pickup_shake_detector (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write_en,
    input  wire logic [mpsd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [mpsd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic signed [15:0]               accel_x,
    input  wire logic signed [15:0]               accel_y,
    input  wire logic signed [15:0]               accel_z,
    input  wire logic signed [15:0]               rate_x,
    input  wire logic signed [15:0]               rate_y,
    input  wire logic signed [15:0]               rate_z,
    input  wire logic [31:0]                      timestamp_ms,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  pickup_event,
    output logic                                  shake_event,
    output logic [16:0]                           rotation_activity,
    output logic [31:0]                           norm_change
);
    import mpsd_pkg::*;

    cfg_t cfg_reg;

    logic              s1_valid_reg;
    logic [NORM_W-1:0] s1_norm_reg;
    logic [ROT_W-1:0]  s1_rot_reg;
    logic [TIME_W-1:0] s1_time_reg;

    logic              out_valid_reg;
    logic              out_pick_reg, out_shake_reg;
    logic [ROT_W-1:0]  out_rot_reg;
    logic [NORM_W-1:0] out_change_reg;

    logic        in_accept, out_free, s1_move;
    logic [15:0] mx, my, mz;
    logic [31:0] sq_x, sq_y, sq_z;
    logic [NORM_W-1:0] norm_calc;
    logic [ROT_W-1:0]  rot_calc;
    det_result_t det;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pickup_rot_min     <= RST_PICKUP_ROT_MIN;
            cfg_reg.pickup_delta_min   <= RST_PICKUP_DELTA_MIN;
            cfg_reg.pickup_cooldown    <= RST_PICKUP_COOLDOWN;
            cfg_reg.shake_rot_min      <= RST_SHAKE_ROT_MIN;
            cfg_reg.shake_delta_min    <= RST_SHAKE_DELTA_MIN;
            cfg_reg.shake_peaks_needed <= RST_SHAKE_PEAKS;
            cfg_reg.shake_window       <= RST_SHAKE_WINDOW;
            cfg_reg.shake_peak_gap     <= RST_SHAKE_PEAK_GAP;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index_t'(cfg_index))
                REG_PICKUP_ROT_MIN:   cfg_reg.pickup_rot_min     <= cfg_data[16:0];
                REG_PICKUP_DELTA_MIN: cfg_reg.pickup_delta_min   <= cfg_data;
                REG_PICKUP_COOLDOWN:  cfg_reg.pickup_cooldown    <= cfg_data[15:0];
                REG_SHAKE_ROT_MIN:    cfg_reg.shake_rot_min      <= cfg_data[16:0];
                REG_SHAKE_DELTA_MIN:  cfg_reg.shake_delta_min    <= cfg_data;
                REG_SHAKE_PEAKS:      cfg_reg.shake_peaks_needed <= cfg_data[3:0];
                REG_SHAKE_WINDOW:     cfg_reg.shake_window       <= cfg_data[15:0];
                REG_SHAKE_PEAK_GAP:   cfg_reg.shake_peak_gap     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Handshake: the squaring stage empties whenever the result register can load.
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_move   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    // Squaring stage. Each square is at most 2^30, so the sum fits in 32 bits.
    assign mx = mag16(accel_x);
    assign my = mag16(accel_y);
    assign mz = mag16(accel_z);
    assign sq_x = {16'd0, mx} * {16'd0, mx};
    assign sq_y = {16'd0, my} * {16'd0, my};
    assign sq_z = {16'd0, mz} * {16'd0, mz};
    assign norm_calc = sq_x + sq_y + sq_z;
    assign rot_calc = {1'b0, mag16(rate_x)} + {1'b0, mag16(rate_y)} +
                      {1'b0, mag16(rate_z)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_accept)
            s1_valid_reg <= 1'b1;
        else if (s1_move)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_norm_reg <= norm_calc;
            s1_rot_reg  <= rot_calc;
            s1_time_reg <= timestamp_ms;
        end
    end

    mpsd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s1_move),
        .cfg    (cfg_reg),
        .norm   (s1_norm_reg),
        .rot    (s1_rot_reg),
        .now    (s1_time_reg),
        .result (det)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_move)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_pick_reg   <= det.pickup_event;
            out_shake_reg  <= det.shake_event;
            out_rot_reg    <= s1_rot_reg;
            out_change_reg <= det.norm_change;
        end
    end

    assign out_valid         = out_valid_reg;
    assign pickup_event      = out_pick_reg;
    assign shake_event       = out_shake_reg;
    assign rotation_activity = out_rot_reg;
    assign norm_change       = out_change_reg;

endmodule

`default_nettype wire
